>>> sv/htab_pkg.sv
// ----------------------------------------------------------------------------
// htab_pkg: shared types and constants for the typed handle table
// Table geometry, operation and status codes, entry word layout and the
// write port bundle used between the control logic and the entry store.
// ----------------------------------------------------------------------------
package htab_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int OBJ_W       = 32;
	localparam int OP_W        = 2;
	localparam int ST_W        = 3;
	localparam int KIND_W      = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_LOOKUP = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADIDX   = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_CORRUPT  = 3'd4
	} status_t;

	// Stored kind; credential and context match the one-bit request type.
	localparam logic [KIND_W-1:0] KIND_FREE = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OBJ_W-1:0]  payload;  // object, or next-free link (index + 1, 0 ends)
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] granted;
		logic [OBJ_W-1:0] object;
	} exec_res_t;

endpackage

>>> sv/htab_store.sv
// ----------------------------------------------------------------------------
// htab_store: entry memory
// One write port, two registered read ports; a read of the address being
// written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module htab_store (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [htab_pkg::IDX_W-1:0] rd_a_addr,
	input  logic [htab_pkg::IDX_W-1:0] rd_b_addr,
	input  htab_pkg::mem_wr_t         wr,
	output htab_pkg::entry_t          rd_a_data,
	output htab_pkg::entry_t          rd_b_data
);

	htab_pkg::entry_t mem [htab_pkg::TABLE_DEPTH];
	htab_pkg::entry_t rd_a_q;
	htab_pkg::entry_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			if (wr.en && (wr.addr == rd_a_addr)) begin
				rd_a_q <= wr.data;
			end else begin
				rd_a_q <= mem[rd_a_addr];
			end
			if (wr.en && (wr.addr == rd_b_addr)) begin
				rd_b_q <= wr.data;
			end else begin
				rd_b_q <= mem[rd_b_addr];
			end
		end
	end

	assign rd_a_data = rd_a_q;
	assign rd_b_data = rd_b_q;

endmodule

>>> sv/htab_exec.sv
// ----------------------------------------------------------------------------
// htab_exec: operation logic and list state
// Decides one request from the registered entry words, produces the result
// and the entry write, and keeps free-list head, list flag and use count.
// ----------------------------------------------------------------------------
module htab_exec (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [htab_pkg::OP_W-1:0]  op,
	input  logic [htab_pkg::IDX_W-1:0] idx,
	input  logic                       kind,
	input  logic [htab_pkg::OBJ_W-1:0] obj,
	input  htab_pkg::entry_t           ent_idx,
	input  htab_pkg::entry_t           ent_head,
	output logic [htab_pkg::IDX_W-1:0] head_nxt,
	output htab_pkg::mem_wr_t          wr,
	output htab_pkg::exec_res_t        res
);

	logic [htab_pkg::IDX_W-1:0] free_head_q;
	logic                       nonempty_q;
	logic [htab_pkg::CNT_W-1:0] used_count_q;

	logic [htab_pkg::IDX_W-1:0] head_d;
	logic                       nonempty_d;
	logic [htab_pkg::CNT_W-1:0] used_d;
	htab_pkg::mem_wr_t          wr_d;
	htab_pkg::exec_res_t        res_d;

	always_comb begin
		logic [htab_pkg::OBJ_W-1:0]  link;
		logic [htab_pkg::OBJ_W-1:0]  link_m1;
		logic [htab_pkg::KIND_W-1:0] req_kind;
		head_d     = free_head_q;
		nonempty_d = nonempty_q;
		used_d     = used_count_q;
		wr_d       = '0;
		res_d      = '0;
		res_d.status = htab_pkg::ST_OK;
		link       = ent_head.payload;
		link_m1    = link - htab_pkg::OBJ_W'(1);
		req_kind   = htab_pkg::KIND_W'(kind);
		case (op)
			htab_pkg::OP_ALLOC: begin
				if (nonempty_q) begin
					if (ent_head.kind != htab_pkg::KIND_FREE) begin
						res_d.status = htab_pkg::ST_CORRUPT;
					end else begin
						// pop: last entry in the list, or follow the link
						if ((link == '0) || (link > htab_pkg::OBJ_W'(htab_pkg::TABLE_DEPTH))) begin
							nonempty_d = 1'b0;
							head_d     = '0;
						end else begin
							head_d = link_m1[htab_pkg::IDX_W-1:0];
						end
						wr_d.en           = 1'b1;
						wr_d.addr         = free_head_q;
						wr_d.data.kind    = req_kind;
						wr_d.data.payload = obj;
						res_d.granted     = free_head_q;
					end
				end else if (used_count_q < htab_pkg::CNT_W'(htab_pkg::TABLE_DEPTH)) begin
					used_d            = used_count_q + htab_pkg::CNT_W'(1);
					wr_d.en           = 1'b1;
					wr_d.addr         = used_count_q[htab_pkg::IDX_W-1:0];
					wr_d.data.kind    = req_kind;
					wr_d.data.payload = obj;
					res_d.granted     = used_count_q[htab_pkg::IDX_W-1:0];
				end else begin
					res_d.status = htab_pkg::ST_FULL;
				end
			end
			htab_pkg::OP_FREE, htab_pkg::OP_LOOKUP: begin
				if (htab_pkg::CNT_W'(idx) >= used_count_q) begin
					res_d.status = htab_pkg::ST_BADIDX;
				end else if (ent_idx.kind != req_kind) begin
					res_d.status = htab_pkg::ST_MISMATCH;
				end else begin
					res_d.object = ent_idx.payload;
					if (op == htab_pkg::OP_FREE) begin
						// push onto the list; the old head becomes the link
						wr_d.en        = 1'b1;
						wr_d.addr      = idx;
						wr_d.data.kind = htab_pkg::KIND_FREE;
						wr_d.data.payload = nonempty_q ?
							htab_pkg::OBJ_W'(free_head_q) + htab_pkg::OBJ_W'(1) : '0;
						head_d     = idx;
						nonempty_d = 1'b1;
					end
				end
			end
			default: begin
				res_d.status = htab_pkg::ST_BADIDX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			nonempty_q   <= 1'b0;
			used_count_q <= '0;
		end else if (fire) begin
			free_head_q  <= head_d;
			nonempty_q   <= nonempty_d;
			used_count_q <= used_d;
		end
	end

	assign head_nxt = fire ? head_d : free_head_q;
	assign wr       = fire ? wr_d : '0;
	assign res      = res_d;

endmodule

>>> sv/typed_handle_table_allocator_core.sv
// ----------------------------------------------------------------------------
// typed_handle_table_allocator_core: typed handle table with free list
// Allocate, free and lookup of typed handles over a 64-entry table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: opcode,
//   handle_index, entry_type and object_value. Output channel (out_valid /
//   out_stall) returns one result word per request: status, granted_index
//   and object_out. A word moves on an edge with valid high and stall low.
//   Throughput: one request per cycle while the output is not stalled. At the
//   accept edge the entry store is read at handle_index and at the free-list
//   head the previous request leaves behind; when the input stage fires, the
//   request is decided, the entry written back and the result register
//   loaded. Same-cycle write/read collisions in the store are forwarded,
//   so back-to-back requests see each other.
//   Reset clears the free-list head, list flag, use count and both valid
//   flags; table contents are left as they are, and entries never handed
//   out are rejected by the use count, so no clearing pass is needed.
//   When the receiver stalls, the result holds; one more request may sit in
//   the input stage, after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module typed_handle_table_allocator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [htab_pkg::OP_W-1:0]  opcode,
	input  logic [htab_pkg::IDX_W-1:0] handle_index,
	input  logic                       entry_type,
	input  logic [htab_pkg::OBJ_W-1:0] object_value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [htab_pkg::ST_W-1:0]  status,
	output logic [htab_pkg::IDX_W-1:0] granted_index,
	output logic [htab_pkg::OBJ_W-1:0] object_out
);

	// input stage
	logic                       vld_s1;
	logic [htab_pkg::OP_W-1:0]  op_s1;
	logic [htab_pkg::IDX_W-1:0] idx_s1;
	logic                       kind_s1;
	logic [htab_pkg::OBJ_W-1:0] obj_s1;

	// result stage
	logic                       vld_s2;
	htab_pkg::exec_res_t        res_s2;

	logic                       fire;    // input stage decides and moves on
	logic                       accept;  // request word taken
	logic [htab_pkg::IDX_W-1:0] head_nxt;
	htab_pkg::mem_wr_t          wr;
	htab_pkg::entry_t           ent_idx;
	htab_pkg::entry_t           ent_head;
	htab_pkg::exec_res_t        res;

	assign fire     = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	// entry store: port A at the request index, port B at the list head
	htab_store u_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_a_addr (handle_index),
		.rd_b_addr (head_nxt),
		.wr        (wr),
		.rd_a_data (ent_idx),
		.rd_b_data (ent_head)
	);

	htab_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (op_s1),
		.idx      (idx_s1),
		.kind     (kind_s1),
		.obj      (obj_s1),
		.ent_idx  (ent_idx),
		.ent_head (ent_head),
		.head_nxt (head_nxt),
		.wr       (wr),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				vld_s2 <= 1'b1;
			end else if (!out_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			idx_s1  <= handle_index;
			kind_s1 <= entry_type;
			obj_s1  <= object_value;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = vld_s2;
	assign status        = res_s2.status;
	assign granted_index = res_s2.granted;
	assign object_out    = res_s2.object;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for typed_handle_table_allocator_core
// Drives allocate, free and lookup words with random gaps, keeps its own copy
// of the handle table and the free list, and checks each result word against
// the predicted one in order. Covers the full table, backpressure and a long
// run of mixed traffic that fills and drains the table several times.
// ----------------------------------------------------------------------------
module tb;

	import htab_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;   // no such operation
	localparam int              IDLE_LIMIT = 2000;   // cycles without any transfer
	localparam int              RAND_WORDS = 1500;

	// DUT ports
	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     opcode;
	logic [IDX_W-1:0]    handle_index;
	logic                entry_type;
	logic [OBJ_W-1:0]    object_value;
	logic                out_valid;
	logic                out_stall;
	logic [ST_W-1:0]     status;
	logic [IDX_W-1:0]    granted_index;
	logic [OBJ_W-1:0]    object_out;

	// Shadow of the handle table. Entries at or above issued_cnt are never read.
	logic [KIND_W-1:0]   tbl_kind [TABLE_DEPTH];
	logic [OBJ_W-1:0]    tbl_word [TABLE_DEPTH];   // object, or link (index + 1, 0 ends)
	logic [IDX_W-1:0]    head_idx;
	logic                list_live;
	int                  issued_cnt;

	exec_res_t           awaited_results [$];

	int                  err_cnt;
	int                  idle_cycles;
	bit                  tx_eager;      // sender offers back to back
	bit                  rx_eager;      // receiver never stalls
	int                  rx_wait;       // stall cycles drawn for the next result word
	int                  hold_ask;      // request for a long receiver hold-off
	int                  hold_left;

	typed_handle_table_allocator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.handle_index  (handle_index),
		.entry_type    (entry_type),
		.object_value  (object_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.granted_index (granted_index),
		.object_out    (object_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int draw_wait(input bit eager);
		return eager ? 0 : $urandom_range(0, 9);
	endfunction

	// Applies one request to the shadow table and returns the result word it
	// must produce.
	function automatic exec_res_t predict_table_op(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx, input logic typ, input logic [OBJ_W-1:0] obj);
		exec_res_t        res;
		logic [IDX_W-1:0] slot;
		logic [OBJ_W-1:0] link;
		res = '0;
		res.status = ST_OK;
		case (op)
			OP_ALLOC: begin
				if (list_live) begin
					slot = head_idx;
					if (tbl_kind[slot] != KIND_FREE) begin
						// head not marked free: refuse, touch nothing
						res.status = ST_CORRUPT;
					end else begin
						link = tbl_word[slot];
						if (link == '0 || link > TABLE_DEPTH) begin
							list_live = 1'b0;
							head_idx  = '0;
						end else begin
							head_idx = IDX_W'(link - OBJ_W'(1));
						end
						tbl_word[slot] = obj;
						tbl_kind[slot] = {1'b0, typ};
						res.granted    = slot;
					end
				end else if (issued_cnt < TABLE_DEPTH) begin
					slot = IDX_W'(issued_cnt);
					issued_cnt++;
					tbl_word[slot] = obj;
					tbl_kind[slot] = {1'b0, typ};
					res.granted    = slot;
				end else begin
					res.status = ST_FULL;
				end
			end
			OP_FREE, OP_LOOKUP: begin
				if (idx >= issued_cnt) begin
					res.status = ST_BADIDX;
				end else if (tbl_kind[idx] != {1'b0, typ}) begin
					// a free entry never matches either handle kind
					res.status = ST_MISMATCH;
				end else begin
					res.object = tbl_word[idx];
					if (op == OP_FREE) begin
						tbl_word[idx] = list_live ? OBJ_W'(head_idx) + OBJ_W'(1) : '0;
						tbl_kind[idx] = KIND_FREE;
						head_idx      = idx;
						list_live     = 1'b1;
					end
				end
			end
			default: res.status = ST_BADIDX;
		endcase
		return res;
	endfunction

	// Random index of an entry currently handed out, or -1 if none.
	function automatic int find_live();
		int start;
		int j;
		if (issued_cnt == 0)
			return -1;
		start = $urandom_range(0, issued_cnt - 1);
		for (int k = 0; k < issued_cnt; k++) begin
			j = (start + k) % issued_cnt;
			if (tbl_kind[j] != KIND_FREE)
				return j;
		end
		return -1;
	endfunction

	// Offers one request word after a drawn gap and waits for it to be taken.
	// Valid is left high so the next call can follow without a bubble.
	task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic typ, input logic [OBJ_W-1:0] obj);
		int gap;
		gap = draw_wait(tx_eager);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		opcode       <= op;
		handle_index <= idx;
		entry_type   <= typ;
		object_value <= obj;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		awaited_results.push_back(predict_table_op(op, idx, typ, obj));
	endtask

	// Drops valid and holds the input idle until every result word is back.
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Every operation and the edge cases, on a fresh table.
	task automatic test_basic_ops();
		send_word(OP_LOOKUP, 6'd0,  1'b0, 32'h0);            // empty table
		send_word(OP_FREE,   6'd63, 1'b1, 32'hFFFF_FFFF);    // top index, never used
		send_word(OP_UNUSED, 6'd0,  1'b0, 32'h0);
		send_word(OP_ALLOC,  6'd0,  1'b0, 32'h0000_0000);
		send_word(OP_ALLOC,  6'd0,  1'b1, 32'hFFFF_FFFF);
		send_word(OP_ALLOC,  6'd63, 1'b0, 32'hA5A5_A5A5);    // index ignored on allocate
		send_word(OP_LOOKUP, 6'd0,  1'b0, 32'hFFFF_FFFF);
		send_word(OP_LOOKUP, 6'd1,  1'b1, 32'h0);
		send_word(OP_LOOKUP, 6'd1,  1'b0, 32'h0);            // wrong kind
		send_word(OP_LOOKUP, 6'd3,  1'b0, 32'h0);            // just past the used range
		send_word(OP_FREE,   6'd1,  1'b1, 32'h0);
		send_word(OP_FREE,   6'd1,  1'b1, 32'h0);            // double free
		send_word(OP_LOOKUP, 6'd1,  1'b1, 32'h0);            // lookup of a free entry
		send_word(OP_FREE,   6'd0,  1'b0, 32'h0);            // list is now 0 -> 1
		send_word(OP_ALLOC,  6'd0,  1'b1, 32'h5A5A_5A5A);    // pops 0
		send_word(OP_ALLOC,  6'd0,  1'b0, 32'h1234_5678);    // pops 1, list empties
		send_word(OP_ALLOC,  6'd0,  1'b1, 32'h8000_0001);    // fresh entry again
		send_word(OP_LOOKUP, 6'd2,  1'b0, 32'h0);
		send_word(OP_UNUSED, 6'd2,  1'b1, 32'hFFFF_FFFF);
	endtask

	// Fills every entry, then checks full, free and reuse on a full table.
	task automatic test_table_full();
		int live;
		while (issued_cnt < TABLE_DEPTH || list_live)
			send_word(OP_ALLOC, IDX_W'($urandom), 1'($urandom), OBJ_W'($urandom));
		send_word(OP_ALLOC, IDX_W'($urandom), 1'b0, OBJ_W'($urandom));
		send_word(OP_ALLOC, IDX_W'($urandom), 1'b1, OBJ_W'($urandom));
		live = find_live();
		send_word(OP_FREE, IDX_W'(live), tbl_kind[live][0], OBJ_W'($urandom));
		send_word(OP_ALLOC, IDX_W'($urandom), 1'($urandom), OBJ_W'($urandom));
		send_word(OP_ALLOC, IDX_W'($urandom), 1'($urandom), OBJ_W'($urandom));
	endtask

	// Receiver holds off for a long stretch while words keep coming, so the
	// block fills up and raises in_stall.
	task automatic test_backpressure();
		int live;
		hold_ask = 150;
		tx_eager = 1'b1;
		for (int n = 0; n < 16; n++) begin
			live = find_live();
			if (n % 3 == 0 || live < 0)
				send_word(OP_ALLOC, IDX_W'($urandom), 1'($urandom), OBJ_W'($urandom));
			else if (n % 3 == 1)
				send_word(OP_FREE, IDX_W'(live), tbl_kind[live][0], OBJ_W'($urandom));
			else
				send_word(OP_LOOKUP, IDX_W'(live), tbl_kind[live][0], OBJ_W'($urandom));
		end
		tx_eager = 1'b0;
	endtask

	// Mixed traffic. Stretches alternate between allocate-heavy and free-heavy
	// so the table fills and drains repeatedly; most frees and lookups target
	// a live entry with the right kind, the rest are wrong kind or random.
	task automatic test_random_traffic(input int n_words);
		int               seg_left;
		int               alloc_pct;
		int               r;
		int               pick;
		int               live;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic             typ;
		logic [OBJ_W-1:0] obj;
		seg_left  = 0;
		alloc_pct = 50;
		for (int n = 0; n < n_words; n++) begin
			if (seg_left == 0) begin
				seg_left  = $urandom_range(80, 200);
				alloc_pct = (alloc_pct > 50) ? $urandom_range(15, 35) : $urandom_range(60, 85);
				tx_eager  = ($urandom_range(0, 3) == 0);
				rx_eager  = ($urandom_range(0, 3) == 0);
			end
			seg_left--;
			idx = IDX_W'($urandom);
			typ = 1'($urandom);
			obj = OBJ_W'($urandom);
			r   = $urandom_range(0, 99);
			if (r < 3) begin
				op = OP_UNUSED;
			end else if (r < 3 + alloc_pct) begin
				op = OP_ALLOC;
			end else begin
				op   = $urandom_range(0, 1) ? OP_FREE : OP_LOOKUP;
				pick = $urandom_range(0, 99);
				live = find_live();
				if (live >= 0 && pick < 85) begin
					idx = IDX_W'(live);
					typ = tbl_kind[live][0] ^ (pick >= 75);
				end
			end
			send_word(op, idx, typ, obj);
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	// Receiver: per-word stall draw, plus the long hold-off when asked.
	always @(negedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result check, in order, field by field; also feeds the watchdog.
	always @(posedge clk) begin : result_check
		exec_res_t want;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result word with none awaited: status %0d index %0d object %h",
					$time, status, granted_index, object_out);
				err_cnt++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, want.status, status);
					err_cnt++;
				end
				if (granted_index !== want.granted) begin
					$display("%0t: granted_index expected %0d, got %0d",
						$time, want.granted, granted_index);
					err_cnt++;
				end
				if (object_out !== want.object) begin
					$display("%0t: object_out expected %h, got %h",
						$time, want.object, object_out);
					err_cnt++;
				end
			end
			rx_wait = draw_wait(rx_eager);
		end
	end

	// Watchdog: too long without any word moving on either channel.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_ALLOC;
		handle_index = '0;
		entry_type   = 1'b0;
		object_value = '0;
		out_stall    = 1'b0;
		err_cnt      = 0;
		tx_eager     = 1'b0;
		rx_eager     = 1'b0;
		rx_wait      = 0;
		hold_ask     = 0;
		hold_left    = 0;
		head_idx     = '0;
		list_live    = 1'b0;
		issued_cnt   = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_kind[i] = '0;
			tbl_word[i] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		wait_for_drain();
		test_table_full();
		wait_for_drain();
		test_backpressure();
		wait_for_drain();
		test_random_traffic(RAND_WORDS);
		wait_for_drain();

		// spare cycles to catch any stray result word
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
sv/htab_pkg.sv
sv/htab_store.sv
sv/htab_exec.sv
sv/typed_handle_table_allocator_core.sv
tb/sv/tb.sv
